>>> src/pmct_pkg.sv
// ----------------------------------------------------------------------------
// pmct_pkg
// Shared types, register indexes, reset values and small arithmetic helpers
// for the PS/2 mouse packet cursor tracker.
// ----------------------------------------------------------------------------
package pmct_pkg;

    // Default cursor coordinate width.
    localparam int COORD_WIDTH_DEF = 12;

    // Configuration port geometry.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // Register indexes on the configuration port.
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_X        = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_Y        = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MOTION_LEVEL = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_WHEEL_MODE   = 3'd3;

    // Reset values.
    localparam int MAX_X_RST = 1023;
    localparam int MAX_Y_RST = 767;
    localparam int POS_X_RST = 511;
    localparam int POS_Y_RST = 383;
    localparam logic [2:0] LEVEL_RST = 3'd2;

    // Item kinds.
    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_POLL = 1'b1;

    // Width of a scaled motion delta: -512..508.
    localparam int DELTA_W = 11;

    // One input word.
    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
    } pmct_item_t;

    // Mode registers that are not coordinates.
    typedef struct packed {
        logic [2:0] motion_level;
        logic       wheel_mode;
    } pmct_ctrl_t;

    // Tracker status that travels with a report.
    typedef struct packed {
        logic [2:0]        button_bits;
        logic signed [7:0] wheel_sum;
        logic              changed;
    } pmct_status_t;

    // Out-of-range levels act as the nearest legal one.
    function automatic logic [2:0] clamp_level(input logic [2:0] lv);
        logic [2:0] r;
        if (lv == 3'd0)
            r = 3'd1;
        else if (lv > 3'd4)
            r = 3'd4;
        else
            r = lv;
        return r;
    endfunction

    // Signed byte times a level of 1..4, built from shifts and one add.
    function automatic logic signed [DELTA_W-1:0] scale_delta(
        input logic [7:0] b,
        input logic [2:0] lv
    );
        logic signed [DELTA_W-1:0] s;
        logic signed [DELTA_W-1:0] r;
        s = $signed({{(DELTA_W-8){b[7]}}, b});
        case (lv)
            3'd1:    r = s;
            3'd2:    r = s <<< 1;
            3'd3:    r = s + (s <<< 1);
            default: r = s <<< 2;
        endcase
        return r;
    endfunction

    // Wheel sum plus a 4-bit signed step, saturated to -128..127.
    function automatic logic signed [7:0] sat_wheel(
        input logic signed [7:0] sum,
        input logic signed [3:0] step
    );
        logic signed [8:0] t;
        logic signed [7:0] r;
        t = 9'(sum) + 9'(step);
        if (t > 9'sd127)
            r = 8'sd127;
        else if (t < -9'sd128)
            r = -8'sd128;
        else
            r = t[7:0];
        return r;
    endfunction

endpackage

>>> src/pmct_cfg_regs.sv
// ----------------------------------------------------------------------------
// pmct_cfg_regs
// Configuration register file: cursor bounds, motion level and wheel mode.
// ----------------------------------------------------------------------------
module pmct_cfg_regs
    import pmct_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output logic [COORD_WIDTH-1:0] max_x,
    output logic [COORD_WIDTH-1:0] max_y,
    output pmct_ctrl_t             ctrl
);

    logic [COORD_WIDTH-1:0] max_x_reg;
    logic [COORD_WIDTH-1:0] max_y_reg;
    pmct_ctrl_t             ctrl_reg;

    // Writes are always taken; unknown indexes are ignored.
    assign cfg_ready = 1'b1;

    // Register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_x_reg             <= COORD_WIDTH'(MAX_X_RST);
            max_y_reg             <= COORD_WIDTH'(MAX_Y_RST);
            ctrl_reg.motion_level <= LEVEL_RST;
            ctrl_reg.wheel_mode   <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_MAX_X:        max_x_reg             <= cfg_data[COORD_WIDTH-1:0];
                REG_MAX_Y:        max_y_reg             <= cfg_data[COORD_WIDTH-1:0];
                REG_MOTION_LEVEL: ctrl_reg.motion_level <= cfg_data[2:0];
                REG_WHEEL_MODE:   ctrl_reg.wheel_mode   <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    assign max_x = max_x_reg;
    assign max_y = max_y_reg;
    assign ctrl  = ctrl_reg;

endmodule

>>> src/pmct_in_stage.sv
// ----------------------------------------------------------------------------
// pmct_in_stage
// Input register. Holds one word and releases it to the tracker core unless
// it is a poll that would find the result register occupied.
// ----------------------------------------------------------------------------
module pmct_in_stage
    import pmct_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  pmct_item_t in_item,
    input  logic       out_busy,
    output logic       fire,
    output pmct_item_t item
);

    logic       valid_reg;
    pmct_item_t item_reg;
    logic       blocked;

    // Only a poll needs the result register; data bytes always proceed.
    assign blocked  = valid_reg && (item_reg.kind == KIND_POLL) && out_busy;
    assign fire     = valid_reg && !blocked;
    assign in_stall = blocked;

    // Valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (!blocked)
            valid_reg <= in_valid;
    end

    // Held word.
    always_ff @(posedge clk)
    begin
        if (!blocked && in_valid)
            item_reg <= in_item;
    end

    assign item = item_reg;

endmodule

>>> src/pmct_core.sv
// ----------------------------------------------------------------------------
// pmct_core
// Packet assembly and cursor state. While fire is high one word is applied per
// cycle: bytes form packets, a finished packet moves the clamped cursor, and a
// poll with changes hands state to the result register and clears change flag.
// ----------------------------------------------------------------------------
module pmct_core
    import pmct_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   fire,
    input  pmct_item_t             item,
    input  logic [COORD_WIDTH-1:0] max_x,
    input  logic [COORD_WIDTH-1:0] max_y,
    input  pmct_ctrl_t             ctrl,
    output logic [COORD_WIDTH-1:0] pos_x,
    output logic [COORD_WIDTH-1:0] pos_y,
    output pmct_status_t           status,
    output logic                   report_fire
);

    localparam int SUM_W = ((COORD_WIDTH > DELTA_W - 1) ? COORD_WIDTH : DELTA_W - 1) + 2;

    logic [7:0]             pb0_reg;
    logic [7:0]             pb1_reg;
    logic [7:0]             pb2_reg;
    logic [1:0]             bpos_reg;
    logic [COORD_WIDTH-1:0] pos_x_reg;
    logic [COORD_WIDTH-1:0] pos_y_reg;
    logic [2:0]             btn_reg;
    logic signed [7:0]      wheel_reg;
    logic                   changed_reg;

    logic                      take;
    logic                      finish;
    logic [1:0]                last_pos;
    logic [7:0]                b2;
    logic [2:0]                level;
    logic signed [3:0]         step;
    logic signed [DELTA_W-1:0] dx;
    logic signed [DELTA_W-1:0] dy;
    logic signed [SUM_W-1:0]   sum_x;
    logic signed [SUM_W-1:0]   sum_y;
    logic signed [SUM_W-1:0]   lim_x;
    logic signed [SUM_W-1:0]   lim_y;
    logic [COORD_WIDTH-1:0]    pos_x_next;
    logic [COORD_WIDTH-1:0]    pos_y_next;
    logic                      update;
    logic signed [7:0]         wheel_next;

    // A byte is kept unless it is a first byte without the sync bit.
    assign take = fire && (item.kind == KIND_DATA) &&
                  !((bpos_reg == 2'd0) && !item.data_byte[3]);

    // The packet ends once the position reaches the last byte of the current packet.
    assign last_pos = ctrl.wheel_mode ? 2'd3 : 2'd2;
    assign finish   = (bpos_reg >= last_pos);

    // Third byte comes straight from the input when it is the last one.
    assign b2    = (bpos_reg == 2'd2) ? item.data_byte : pb2_reg;
    assign level = clamp_level(ctrl.motion_level);
    assign step  = (ctrl.wheel_mode && (bpos_reg == 2'd3)) ? $signed(item.data_byte[3:0])
                                                          : 4'sd0;
    assign dx    = scale_delta(pb1_reg, level);
    assign dy    = -scale_delta(b2, level);

    // New cursor, clamped to the configured bounds.
    assign sum_x = $signed({{(SUM_W-COORD_WIDTH){1'b0}}, pos_x_reg}) + SUM_W'(dx);
    assign sum_y = $signed({{(SUM_W-COORD_WIDTH){1'b0}}, pos_y_reg}) + SUM_W'(dy);
    assign lim_x = $signed({{(SUM_W-COORD_WIDTH){1'b0}}, max_x});
    assign lim_y = $signed({{(SUM_W-COORD_WIDTH){1'b0}}, max_y});

    always_comb
    begin
        if (sum_x < 0)
            pos_x_next = '0;
        else if (sum_x > lim_x)
            pos_x_next = max_x;
        else
            pos_x_next = sum_x[COORD_WIDTH-1:0];

        if (sum_y < 0)
            pos_y_next = '0;
        else if (sum_y > lim_y)
            pos_y_next = max_y;
        else
            pos_y_next = sum_y[COORD_WIDTH-1:0];
    end

    // A clean packet that changes anything updates the state.
    assign update = take && finish && (pb0_reg[7:6] == 2'b00) &&
                    ((pos_x_next != pos_x_reg) || (pos_y_next != pos_y_reg) ||
                     (pb0_reg[2:0] != btn_reg) || (step != 4'sd0));

    assign wheel_next  = sat_wheel(wheel_reg, step);
    assign report_fire = fire && (item.kind == KIND_POLL) && changed_reg;

    // Packet assembly.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pb0_reg  <= '0;
            pb1_reg  <= '0;
            pb2_reg  <= '0;
            bpos_reg <= '0;
        end
        else if (take)
        begin
            case (bpos_reg)
                2'd0:    pb0_reg <= item.data_byte;
                2'd1:    pb1_reg <= item.data_byte;
                2'd2:    pb2_reg <= item.data_byte;
                default: ;
            endcase
            bpos_reg <= finish ? 2'd0 : bpos_reg + 2'd1;
        end
    end

    // Cursor, buttons, wheel sum and change flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg   <= COORD_WIDTH'(POS_X_RST);
            pos_y_reg   <= COORD_WIDTH'(POS_Y_RST);
            btn_reg     <= '0;
            wheel_reg   <= '0;
            changed_reg <= 1'b0;
        end
        else if (update)
        begin
            pos_x_reg   <= pos_x_next;
            pos_y_reg   <= pos_y_next;
            btn_reg     <= pb0_reg[2:0];
            wheel_reg   <= wheel_next;
            changed_reg <= 1'b1;
        end
        else if (report_fire)
        begin
            wheel_reg   <= '0;
            changed_reg <= 1'b0;
        end
    end

    assign pos_x              = pos_x_reg;
    assign pos_y              = pos_y_reg;
    assign status.button_bits = btn_reg;
    assign status.wheel_sum   = wheel_reg;
    assign status.changed     = changed_reg;

endmodule

>>> src/pmct_out_stage.sv
// ----------------------------------------------------------------------------
// pmct_out_stage
// Result register. Captures a report and holds it until the consumer takes it.
// ----------------------------------------------------------------------------
module pmct_out_stage
    import pmct_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    input  logic [COORD_WIDTH-1:0] pos_x,
    input  logic [COORD_WIDTH-1:0] pos_y,
    input  pmct_status_t           status,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   out_busy,
    output logic [COORD_WIDTH-1:0] cursor_x,
    output logic [COORD_WIDTH-1:0] cursor_y,
    output logic                   left_down,
    output logic                   right_down,
    output logic                   middle_down,
    output logic signed [7:0]      scroll_sum
);

    logic                   valid_reg;
    logic [COORD_WIDTH-1:0] x_reg;
    logic [COORD_WIDTH-1:0] y_reg;
    logic [2:0]             btn_reg;
    logic signed [7:0]      wheel_reg;

    // The slot is busy while a word is held and not being taken.
    assign out_busy = valid_reg && out_stall;

    // Valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= 1'b1;
        else if (!out_stall)
            valid_reg <= 1'b0;
    end

    // Report payload.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            x_reg     <= pos_x;
            y_reg     <= pos_y;
            btn_reg   <= status.button_bits;
            wheel_reg <= status.wheel_sum;
        end
    end

    assign out_valid   = valid_reg;
    assign cursor_x    = x_reg;
    assign cursor_y    = y_reg;
    assign left_down   = btn_reg[0];
    assign right_down  = btn_reg[1];
    assign middle_down = btn_reg[2];
    assign scroll_sum  = wheel_reg;

endmodule

>>> src/ps2_mouse_packet_cursor_tracker_unit.sv
// ----------------------------------------------------------------------------
// ps2_mouse_packet_cursor_tracker_unit
// PS/2 mouse packet decoder with clamped cursor tracking and wheel sum.
//
//   Channel | Signals                                  | Direction
//   --------+------------------------------------------+----------
//   in      | in_valid, in_stall, kind, data_byte      | sink
//   out     | out_valid, out_stall, cursor_x, cursor_y,| source
//           | left_down, right_down, middle_down,      |
//           | scroll_sum                               |
//   cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data| sink
//
// One word is taken per cycle while in_stall is low. An accepted word waits in
// the input register until it is applied to the state; a poll that finds
// changes loads the result register at that same edge, making the report
// visible on the outputs.
// Reset puts the cursor at its center values and clears all flags.
// Only a poll word waiting on a stalled, full result register stalls input.
// ----------------------------------------------------------------------------
module ps2_mouse_packet_cursor_tracker_unit
    import pmct_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   kind,
    input  logic [7:0]             data_byte,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [COORD_WIDTH-1:0] cursor_x,
    output logic [COORD_WIDTH-1:0] cursor_y,
    output logic                   left_down,
    output logic                   right_down,
    output logic                   middle_down,
    output logic signed [7:0]      scroll_sum,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [COORD_WIDTH-1:0] max_x;
    logic [COORD_WIDTH-1:0] max_y;
    pmct_ctrl_t             ctrl;
    pmct_item_t             in_item;
    pmct_item_t             item;
    logic                   fire;
    logic                   out_busy;
    logic [COORD_WIDTH-1:0] pos_x;
    logic [COORD_WIDTH-1:0] pos_y;
    pmct_status_t           status;
    logic                   report_fire;

    assign in_item.kind      = kind;
    assign in_item.data_byte = data_byte;

    // Configuration registers.
    pmct_cfg_regs #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .max_x    (max_x),
        .max_y    (max_y),
        .ctrl     (ctrl)
    );

    // Input register.
    pmct_in_stage u_in (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_item (in_item),
        .out_busy(out_busy),
        .fire    (fire),
        .item    (item)
    );

    // Packet assembly and cursor state.
    pmct_core #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .item       (item),
        .max_x      (max_x),
        .max_y      (max_y),
        .ctrl       (ctrl),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .status     (status),
        .report_fire(report_fire)
    );

    // Result register.
    pmct_out_stage #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (report_fire),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .status     (status),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_busy   (out_busy),
        .cursor_x   (cursor_x),
        .cursor_y   (cursor_y),
        .left_down  (left_down),
        .right_down (right_down),
        .middle_down(middle_down),
        .scroll_sum (scroll_sum)
    );

`ifndef ASSERT_OFF
    // Input stalls only behind a held, stalled result.
    a_stall_needs_full_out: assert property (
        @(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall)
    ) else $error("input stalled while result register could take a word");

    // A new result always comes from a poll word that found changes.
    a_result_from_poll: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(fire && item.kind == KIND_POLL && status.changed)
    ) else $error("result appeared without a poll");

    // A report clears the change flag and the wheel sum.
    a_report_clears: assert property (
        @(posedge clk) disable iff (!rst_n)
        report_fire |=> (!status.changed && status.wheel_sum == 8'sd0)
    ) else $error("change flag or wheel sum survived a report");

    // A pending wheel sum always has a report owed.
    a_wheel_implies_changed: assert property (
        @(posedge clk) disable iff (!rst_n)
        (status.wheel_sum != 8'sd0) |-> status.changed
    ) else $error("wheel sum held with change flag clear");
`endif

endmodule
